// File: rtl/ffpa_pkg.sv
// Shared types and constants for the first-fit partition allocator.
// Depends on nothing; imported by first_fit_partition_allocator_core.
`default_nettype none

package ffpa_pkg;

  // Table depth and partition size width.
  localparam int unsigned MAX_PARTITIONS = 16;
  localparam int unsigned SIZE_BITS      = 16;

  // Derived widths: table index, and a count that can also hold the depth itself.
  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1);

  // Configuration port geometry.
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_TOTAL = 1'b0;  // word select of total_memory

  // Operation codes of an input word.
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Input word.
  typedef struct packed {
    logic                 operation;
    logic [SIZE_BITS-1:0] size;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]           status;
    logic [3:0]           partition_index;
    logic [SIZE_BITS-1:0] unpartitioned;
    logic [SIZE_BITS-1:0] leftover;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/first_fit_partition_allocator_core.sv
// Fixed-partition allocator with first-fit placement over a partition size memory.
// Depends on ffpa_pkg for word types, codes and table geometry.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid_i / in_stall_o      in_word_i  (operation, size)
//   out      output     out_valid_o / out_stall_i    out_word_o (status, index, memory)
//   cfg      input      APB psel/penable/pwrite      total_memory at byte address 0
//
// An add word goes from idle straight to the finish state. An allocate word first
// scans the table in order and examines none on an empty table, else 1 up to the
// partition count; the single read port of the size memory delivers one
// entry per cycle.
// Reset is asynchronous; it empties the table and clears the sums, no sweep needed.
// A stalled result waits in the output register while the next word is accepted.
`default_nettype none

module first_fit_partition_allocator_core
  import ffpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input words
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_word_t           in_word_i,
  // Result words
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_word_t          out_word_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  // Saturating subtract for the remaining-memory figures.
  function automatic logic [SIZE_BITS-1:0] sat_sub(input logic [SIZE_BITS-1:0] a,
                                                   input logic [SIZE_BITS-1:0] b);
    sat_sub = (a >= b) ? (a - b) : '0;
  endfunction

  state_e                state_q, state_d;
  logic [SIZE_BITS-1:0]  total_q;
  logic [CNT_W-1:0]      count_q;
  logic [SIZE_BITS-1:0]  used_q;
  logic [SIZE_BITS-1:0]  alloc_q;
  logic [MAX_PARTITIONS-1:0] occ_q;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [SIZE_BITS-1:0]  req_q;
  status_e               status_q;
  logic [IDX_W-1:0]      index_q;
  logic                  out_valid_q;
  out_word_t             out_word_q;

  logic [SIZE_BITS-1:0]  size_mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0]  rdata_q;

  logic                  in_acc;
  logic                  is_add;
  logic                  table_full;
  logic                  add_fits;
  logic                  add_ok;
  logic                  hit;
  logic                  last;
  logic                  out_free;
  logic                  out_load;
  logic                  cfg_wr;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL);
  assign prdata = (paddr[2] == REG_TOTAL) ? PDATA_W'(total_q) : '0;

  // Handshake and decision terms.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign is_add     = (op_e'(in_word_i.operation) == OP_ADD);
  assign table_full = (count_q >= CNT_W'(MAX_PARTITIONS));
  assign add_fits   = (in_word_i.size <= sat_sub(total_q, used_q));
  assign add_ok     = in_acc && is_add && !table_full && add_fits;
  assign hit        = (state_q == ST_SCAN) && !occ_q[ptr_q] && (rdata_q >= req_q);
  assign last       = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_FIN) && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (!is_add && (count_q != '0)) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Scan pointer, which is also the read address of the size memory.
  always_comb begin
    ptr_d = ptr_q;
    case (state_q)
      ST_IDLE: ptr_d = '0;
      ST_SCAN: begin
        if (!hit && !last) begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      default: ptr_d = ptr_q;
    endcase
  end

  // Size memory: written by an accepted add, read one entry a cycle.
  // A write only happens at acceptance and the scan of a later word starts
  // after this word's result is out, so the same entry is never in flight twice.
  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      size_mem[count_q[IDX_W-1:0]] <= in_word_i.size;
    end
    rdata_q <= size_mem[ptr_d];
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      count_q     <= '0;
      used_q      <= '0;
      alloc_q     <= '0;
      occ_q       <= '0;
      ptr_q       <= '0;
      status_q    <= STAT_NO_FIT;
      index_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_wr) begin
        total_q <= pwdata[SIZE_BITS-1:0];
      end
      // Decide an add at once; an allocate starts out as a miss.
      if (in_acc) begin
        index_q <= '0;
        if (!is_add) begin
          status_q <= STAT_NO_FIT;
        end else if (table_full) begin
          status_q <= STAT_FULL;
        end else if (add_fits) begin
          status_q <= STAT_OK;
          index_q  <= count_q[IDX_W-1:0];
        end else begin
          status_q <= STAT_NO_FIT;
        end
      end
      if (add_ok) begin
        count_q                     <= count_q + CNT_W'(1);
        used_q                      <= used_q + in_word_i.size;
        occ_q[count_q[IDX_W-1:0]]   <= 1'b0;
      end
      // First free entry that is large enough takes the request.
      if (hit) begin
        occ_q[ptr_q] <= 1'b1;
        alloc_q      <= alloc_q + req_q;
        status_q     <= STAT_OK;
        index_q      <= ptr_q;
      end
    end
  end

  // Request size and result word need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_word_i.size;
    end
    if (out_load) begin
      out_word_q.status          <= status_q;
      out_word_q.partition_index <= 4'(index_q);
      out_word_q.unpartitioned   <= sat_sub(total_q, used_q);
      out_word_q.leftover        <= sat_sub(total_q, alloc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The partition count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PARTITIONS))
    else $error("partition count beyond table depth");

  // A hit marks its entry occupied in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> occ_q[$past(ptr_q)])
    else $error("allocated entry not marked occupied");

  // A scan leaves the partitioned total alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(used_q) && $stable(count_q))
    else $error("partition table changed during a scan");

  // A table-full result is only given when the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (status_q == STAT_FULL) |-> table_full)
    else $error("table full reported with room left");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for first_fit_partition_allocator_core.
// Depends on ffpa_pkg and the core; a built-in allocator model predicts every result word.
`timescale 1ns / 1ps

module tb_top;
  import ffpa_pkg::*;

  // Idle cycles allowed with no handshake before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Cycles to let the core settle after the last result (longest scan plus margin).
  localparam int unsigned SETTLE_CYCLES = MAX_PARTITIONS + 8;
  localparam int unsigned RANDOM_PHASE_WORDS = 200;
  localparam logic [PADDR_W-1:0] TOTAL_ADDR = {REG_TOTAL, 2'b00};

  // Receiver stall styles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  first_fit_partition_allocator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Allocator model state, kept in step with every accepted input word.
  logic [SIZE_BITS-1:0] part_size [MAX_PARTITIONS];
  logic                 part_taken[MAX_PARTITIONS];
  int unsigned          part_count = 0;
  logic [SIZE_BITS-1:0] mem_assigned = '0;
  logic [SIZE_BITS-1:0] mem_granted = '0;
  logic [SIZE_BITS-1:0] total_mb = '0;

  // Result words predicted but not yet seen on the output.
  out_word_t pending_results[$];

  int unsigned  failures = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  adds_placed = 0;
  int unsigned  allocs_granted = 0;
  int unsigned  full_rejects = 0;
  int unsigned  idle_cycles = 0;
  stall_style_e stall_style = STALL_LIGHT;
  int unsigned  stall_hold = 0;

  // Memory left after subtracting a sum, clamped at zero.
  function automatic logic [SIZE_BITS-1:0] headroom(logic [SIZE_BITS-1:0] whole,
                                                    logic [SIZE_BITS-1:0] spent);
    return (whole >= spent) ? whole - spent : '0;
  endfunction

  // First-fit allocator behavior: updates the model and returns the expected word.
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    logic      found;
    r = '0;
    r.status = STAT_NO_FIT;
    found = 1'b0;
    if (w.operation == OP_ADD) begin
      if (part_count >= MAX_PARTITIONS) begin
        r.status = STAT_FULL;
      end else if (w.size <= headroom(total_mb, mem_assigned)) begin
        part_size[part_count]  = w.size;
        part_taken[part_count] = 1'b0;
        r.partition_index      = 4'(part_count);
        part_count++;
        mem_assigned += w.size;
        r.status = STAT_OK;
      end
    end else begin
      for (int k = 0; k < part_count; k++) begin
        if (!found && !part_taken[k] && part_size[k] >= w.size) begin
          found             = 1'b1;
          part_taken[k]     = 1'b1;
          mem_granted      += w.size;
          r.partition_index = 4'(k);
          r.status          = STAT_OK;
        end
      end
    end
    r.unpartitioned = headroom(total_mb, mem_assigned);
    r.leftover      = headroom(total_mb, mem_granted);
    return r;
  endfunction

  task automatic report_failure(string msg);
    failures++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Present one word and hold it until the core takes it; leaves valid high.
  task automatic send_word(op_e op, logic [SIZE_BITS-1:0] sz);
    in_word_t  w;
    out_word_t r;
    w.operation = op;
    w.size      = sz;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    r = predict_result(w);
    pending_results = {pending_results, r};
    words_sent++;
    if (r.status == STAT_FULL) full_rejects++;
    else if (r.status == STAT_OK && op == OP_ADD) adds_placed++;
    else if (r.status == STAT_OK) allocs_granted++;
  endtask

  // Drop valid and sit out a number of cycles (n must be nonzero).
  task automatic idle_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending until every predicted word has come out and the core is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, access phase held until pready, then back to idle.
  task automatic apb_access(logic wr, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TOTAL_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program total memory while the core is idle, then read it back.
  task automatic set_total(logic [SIZE_BITS-1:0] value);
    logic [PDATA_W-1:0] rd;
    drain();
    apb_access(1'b1, PDATA_W'(value), rd);
    total_mb = value;
    apb_access(1'b0, '0, rd);
    if (rd[SIZE_BITS-1:0] !== value)
      report_failure($sformatf("total_memory read back %0d, wrote %0d", rd, value));
  endtask

  // Random word shaped by the model: mostly oversize adds so the table fills slowly,
  // and allocations that often target a free partition.
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned free_mb;
    int unsigned r;
    int          free_slots[$];
    free_mb     = 32'(headroom(total_mb, mem_assigned));
    r           = $urandom_range(0, 63);
    w.operation = 1'($urandom_range(0, 1));
    if (w.operation == OP_ADD) begin
      if (r == 0) w.size = SIZE_BITS'($urandom_range(0, free_mb));
      else if (r < 9 || free_mb == 65535) w.size = SIZE_BITS'($urandom());
      else w.size = SIZE_BITS'($urandom_range(free_mb + 1, 65535));
    end else begin
      for (int k = 0; k < part_count; k++)
        if (!part_taken[k]) free_slots = {free_slots, k};
      if (r < 22 && free_slots.size() > 0)
        w.size = SIZE_BITS'($urandom_range(0, 32'(part_size[free_slots[$urandom_range(0,
                                 free_slots.size() - 1)]])));
      else if (r < 26) w.size = '0;
      else w.size = SIZE_BITS'($urandom());
    end
    return w;
  endfunction

  // Receiver stall pattern, independent of the sender.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_style)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_hold <= $urandom_range(0, 24);
        end
      endcase
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result word %h", out_word));
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_word.status !== want.status)
          report_failure($sformatf("word %0d status %0d, want %0d",
                                   words_checked, out_word.status, want.status));
        if (out_word.partition_index !== want.partition_index)
          report_failure($sformatf("word %0d index %0d, want %0d",
                                   words_checked, out_word.partition_index,
                                   want.partition_index));
        if (out_word.unpartitioned !== want.unpartitioned)
          report_failure($sformatf("word %0d unpartitioned %0d, want %0d",
                                   words_checked, out_word.unpartitioned,
                                   want.unpartitioned));
        if (out_word.leftover !== want.leftover)
          report_failure($sformatf("word %0d leftover %0d, want %0d",
                                   words_checked, out_word.leftover, want.leftover));
      end
    end
  end

  // Hang detector: any handshake or bus transfer counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, HANG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Placement basics: oversize add, zero-size partition and request, first fit,
  // no fitting partition, and filling memory exactly.
  task automatic test_first_fit_basics();
    stall_style <= STALL_LIGHT;
    set_total(16'd1000);
    send_word(OP_ADD, 16'hFFFF);
    send_word(OP_ADD, 16'd0);
    send_word(OP_ALLOC, 16'd0);
    send_word(OP_ALLOC, 16'd0);
    send_word(OP_ADD, 16'd300);
    send_word(OP_ADD, 16'd100);
    send_word(OP_ALLOC, 16'd200);
    send_word(OP_ALLOC, 16'd150);
    send_word(OP_ALLOC, 16'hFFFF);
    send_word(OP_ALLOC, 16'd100);
    send_word(OP_ADD, 16'd600);
    send_word(OP_ADD, 16'd1);
    send_word(OP_ADD, 16'd0);
  endtask

  // Random traffic in phases with different totals, sender gaps and stall styles.
  task automatic test_random_traffic();
    int unsigned burst;
    in_word_t    w;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_total(SIZE_BITS'($urandom_range(64, 4095)));
        1: set_total(16'hFFFF);
        2: set_total(SIZE_BITS'($urandom_range(0, 32'(mem_assigned))));
        default: set_total(16'd0);
      endcase
      stall_style <= stall_style_e'(phase % 3);
      burst = 0;
      for (int i = 0; i < RANDOM_PHASE_WORDS; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if (phase != 1) idle_input($urandom_range(1, 8));
        end
        // Let everything in flight come out once in the middle of a phase.
        if (phase == 2 && i == RANDOM_PHASE_WORDS / 2) drain();
        w = random_word();
        send_word(op_e'(w.operation), w.size);
        burst--;
      end
    end
  endtask

  // Fill the table, then adds must report a full table before any space check.
  task automatic test_table_full();
    stall_style <= STALL_HEAVY;
    set_total(16'hFFFF);
    while (part_count < MAX_PARTITIONS) send_word(OP_ADD, 16'd0);
    send_word(OP_ADD, 16'hFFFF);
    send_word(OP_ADD, 16'd0);
    send_word(OP_ALLOC, 16'd0);
  endtask

  // Shrink total below the sums so both memory figures clamp at zero.
  task automatic test_saturation();
    stall_style <= STALL_NONE;
    set_total(16'd0);
    send_word(OP_ALLOC, 16'hFFFF);
    send_word(OP_ADD, 16'd0);
    set_total(16'(mem_granted >> 1));
    send_word(OP_ALLOC, 16'd1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_fit_basics();
    test_random_traffic();
    test_table_full();
    test_saturation();
    drain();

    if (pending_results.size() != 0)
      report_failure($sformatf("%0d result words never arrived", pending_results.size()));
    $display("Sent %0d words, checked %0d results: %0d partitions placed,",
             words_sent, words_checked, adds_placed);
    $display("%0d requests granted, %0d adds refused on a full table, %0d mismatches.",
             allocs_granted, full_rejects, failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ffpa_pkg.sv
rtl/first_fit_partition_allocator_core.sv
sim/tb_top.sv
